@@ src/tbcd_pkg.sv @@
// Package: widths, constants and the lane type shared by the BCD converter files.
package tbcd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned RAW_W      = 16;
   localparam int unsigned BCD_W      = 16;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned NUM_DIGITS = BCD_W / DIGIT_W;
   localparam int unsigned SCALED_W   = 18;   // 6*32768 + 8192 fits in 18 bits
   localparam int unsigned NUM_CELLS  = RAW_W; // one shift-and-correct round per cell

   localparam logic [SCALED_W-1:0] BCD_LIMIT   = SCALED_W'(9999);
   localparam logic [DIGIT_W-1:0]  DIGIT_THRESH = DIGIT_W'(4);
   localparam logic [DIGIT_W-1:0]  DIGIT_ADJUST = DIGIT_W'(3);
   localparam logic [DIGIT_W-1:0]  DIGIT_MAX    = DIGIT_W'(9);
   localparam logic [BCD_W-1:0]    BCD_SATURATED = 16'h9999;

   // Data carried from cell to cell along the conversion chain
   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [RAW_W-1:0] bin;   // bits still to be shifted in, MSB first
      logic [BCD_W-1:0] bcd;   // partial packed BCD result
   } lane_type;

endpackage

@@ src/tbcd_req_if.sv @@
// Interface: input channel carrying the two raw sensor bytes.
interface tbcd_req_if import tbcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] raw_low_byte;
   logic [BYTE_W-1:0] raw_high_byte;

   modport source(output valid, output raw_low_byte, output raw_high_byte, input ready);
   modport sink(input valid, input raw_low_byte, input raw_high_byte, output ready);
endinterface

@@ src/tbcd_rsp_if.sv @@
// Interface: result channel carrying sign, packed BCD magnitude and overflow.
interface tbcd_rsp_if import tbcd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             is_negative;
   logic [BCD_W-1:0] bcd_value;
   logic             overflow;

   modport source(output valid, output is_negative, output bcd_value, output overflow,
                  input ready);
   modport sink(input valid, input is_negative, input bcd_value, input overflow,
                output ready);
endinterface

@@ src/tbcd_scale.sv @@
// Front stage: sign, magnitude, scaling to hundredths and saturation at 9999.
module tbcd_scale import tbcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [BYTE_W-1:0] raw_low_byte,
   input  logic [BYTE_W-1:0] raw_high_byte,
   output logic              out_valid_ff,
   output lane_type          out_lane_ff
);

   logic [RAW_W-1:0]    raw;
   logic                neg;
   logic [RAW_W-1:0]    mag;
   logic [SCALED_W-1:0] scaled;
   logic                ovf;
   logic [SCALED_W-1:0] sat;
   lane_type            lane_in;
   logic                valid_in;

   // Take magnitude; the most negative reading wraps to 32768 as unsigned
   assign raw = {raw_high_byte, raw_low_byte};
   assign neg = raw[RAW_W-1];
   assign mag = neg ? (~raw + RAW_W'(1)) : raw;

   // Scale: 6*M + floor(M/4), then clamp to the four-digit limit
   assign scaled = {mag, 2'b00} + {1'b0, mag, 1'b0} + {4'b0000, mag[RAW_W-1:2]};
   assign ovf    = scaled > BCD_LIMIT;
   assign sat    = ovf ? BCD_LIMIT : scaled;

   always_comb begin
      lane_in.neg = neg;
      lane_in.ovf = ovf;
      lane_in.bin = sat[RAW_W-1:0];
      lane_in.bcd = '0;
   end

   assign valid_in = advance ? in_valid : out_valid_ff;

   // Clear valid under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_in;
      end
   end

   // Advance payload only when the chain moves
   always_ff @(posedge clock) begin
      if (advance) begin
         out_lane_ff <= lane_in;
      end
   end

endmodule

@@ src/tbcd_dabble_cell.sv @@
// Chain cell: one double dabble round (correct digits, then shift in one bit).
module tbcd_dabble_cell import tbcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  lane_type in_lane,
   output logic     out_valid_ff,
   output lane_type out_lane_ff
);

   logic [BCD_W-1:0] corrected;
   lane_type         lane_in;
   logic             valid_in;

   // Add 3 to every digit above 4; no digit carries since 9 + 3 fits a nibble
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (in_lane.bcd[d*DIGIT_W +: DIGIT_W] > DIGIT_THRESH) begin
            corrected[d*DIGIT_W +: DIGIT_W] = in_lane.bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJUST;
         end else begin
            corrected[d*DIGIT_W +: DIGIT_W] = in_lane.bcd[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // Shift the next binary bit into the BCD word
   always_comb begin
      lane_in.neg = in_lane.neg;
      lane_in.ovf = in_lane.ovf;
      lane_in.bcd = {corrected[BCD_W-2:0], in_lane.bin[RAW_W-1]};
      lane_in.bin = {in_lane.bin[RAW_W-2:0], 1'b0};
   end

   assign valid_in = advance ? in_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_lane_ff <= lane_in;
      end
   end

endmodule

@@ src/temperature_to_bcd_centidegrees_unit.sv @@
// Top level: raw thermometer reading to sign, packed BCD hundredths and overflow.
//
//   channel  direction  transfer payload
//   req      in         raw_low_byte[7:0], raw_high_byte[7:0]
//   rsp      out        is_negative, bcd_value[15:0], overflow
//
// One reading per cycle while the chain is not stalled; each reading passes through
// one scaling stage, then a chain of 16 cells, one double dabble round each.
// Reset clears the valid flag of every stage; payload registers are not reset.
// The whole chain stalls together while the last cell holds a result that the
// sink has not taken; req.ready follows that condition combinationally.
module temperature_to_bcd_centidegrees_unit import tbcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tbcd_req_if.sink   req,
   tbcd_rsp_if.source rsp
);

   logic     advance;
   logic     stage_valid [0:NUM_CELLS];
   lane_type stage_lane  [0:NUM_CELLS];

   // Move the chain unless the last result is stuck
   assign advance   = !stage_valid[NUM_CELLS] || rsp.ready;
   assign req.ready = advance;

   tbcd_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req.valid),
      .raw_low_byte  (req.raw_low_byte),
      .raw_high_byte (req.raw_high_byte),
      .out_valid_ff  (stage_valid[0]),
      .out_lane_ff   (stage_lane[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      tbcd_dabble_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .in_valid     (stage_valid[i]),
         .in_lane      (stage_lane[i]),
         .out_valid_ff (stage_valid[i+1]),
         .out_lane_ff  (stage_lane[i+1])
      );
   end

   // Drive the result from the last cell
   assign rsp.valid       = stage_valid[NUM_CELLS];
   assign rsp.is_negative = stage_lane[NUM_CELLS].neg;
   assign rsp.bcd_value   = stage_lane[NUM_CELLS].bcd;
   assign rsp.overflow    = stage_lane[NUM_CELLS].ovf;

   // An accepted reading enters the front stage on the next cycle
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> stage_valid[0])
      else $error("accepted reading did not enter the front stage");

   // A stalled chain keeps its occupancy
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> stage_valid[0] == $past(stage_valid[0])
                   && stage_valid[NUM_CELLS/2] == $past(stage_valid[NUM_CELLS/2])
                   && stage_valid[NUM_CELLS])
      else $error("chain occupancy changed during a stall");

   // Saturated results read as all nines
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.overflow |-> rsp.bcd_value == BCD_SATURATED)
      else $error("overflow result not saturated");

   // Every digit of a result is decimal
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.bcd_value[3:0] <= DIGIT_MAX && rsp.bcd_value[7:4] <= DIGIT_MAX
                    && rsp.bcd_value[11:8] <= DIGIT_MAX
                    && rsp.bcd_value[15:12] <= DIGIT_MAX)
      else $error("result digit above nine");

endmodule

@@ test/tb_top.sv @@
// Testbench: checks the thermometer-to-BCD unit against a bit-exact predictor over directed and random traffic.
module tb_top import tbcd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_CENTI     = 9999;
   localparam int unsigned WATCHDOG_MAX  = 1000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned RANDOM_PER_PHASE = 210;

   typedef struct packed {
      logic             is_negative;
      logic [BCD_W-1:0] bcd_value;
      logic             overflow;
   } centi_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tbcd_req_if req_ch ();
   tbcd_rsp_if rsp_ch ();

   temperature_to_bcd_centidegrees_unit dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   logic [RAW_W-1:0]  pending_raw[$];
   centi_reading_type expected_readings[$];
   int unsigned       send_idle_pct  = 0;
   int unsigned       recv_stall_pct = 0;
   int unsigned       error_count    = 0;
   int unsigned       quiet_cycles   = 0;
   logic              req_took       = 1'b0;

   // Scale sixteenths to hundredths, saturate, then convert with shift-and-add-3
   function automatic centi_reading_type predict_centidegrees(logic [RAW_W-1:0] raw);
      centi_reading_type res;
      logic [RAW_W-1:0]  mag;
      logic [17:0]       scaled;
      logic [15:0]       bin;
      logic [BCD_W-1:0]  bcd;
      res.is_negative = raw[RAW_W-1];
      mag = res.is_negative ? (~raw + 1'b1) : raw;
      scaled = 18'(mag) * 18'd6 + 18'(mag >> 2);
      res.overflow = (scaled > 18'(MAX_CENTI));
      if (res.overflow) begin
         scaled = 18'(MAX_CENTI);
      end
      bin = scaled[15:0];
      bcd = '0;
      for (int r = 0; r < 16; r++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd[d*DIGIT_W +: DIGIT_W] > 4'd4) begin
               bcd = bcd + (BCD_W'(3) << (d * DIGIT_W));
            end
         end
         bcd = {bcd[BCD_W-2:0], bin[15-r]};
      end
      res.bcd_value = bcd;
      return res;
   endfunction

   // Favor readings inside the convertible range, with some near the limit and some anywhere
   function automatic logic [RAW_W-1:0] random_reading();
      logic [RAW_W-1:0] mag;
      int unsigned      pick;
      pick = $urandom_range(9);
      if (pick <= 5) begin
         mag = RAW_W'($urandom_range(1599));
      end else if (pick <= 7) begin
         mag = RAW_W'($urandom_range(1610, 1590));
      end else begin
         return RAW_W'($urandom_range(16'hFFFF));
      end
      return $urandom_range(1) ? (~mag + 1'b1) : mag;
   endfunction

   // Clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Input driver: hold the item until its transfer, then present the next or idle
   always @(negedge clock) begin
      logic [RAW_W-1:0] raw;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_took) begin
         if (pending_raw.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            raw = pending_raw.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.raw_low_byte  <= raw[BYTE_W-1:0];
            req_ch.raw_high_byte <= raw[RAW_W-1:BYTE_W];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result sink: stall at random
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: predict on input transfers, check result transfers, run the watchdog
   always @(posedge clock) begin
      centi_reading_type got;
      centi_reading_type want;
      logic              req_fire;
      logic              rsp_fire;
      req_fire = req_ch.valid === 1'b1 && req_ch.ready === 1'b1;
      rsp_fire = rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1;
      req_took <= req_fire;
      if (req_fire) begin
         expected_readings.push_back(
            predict_centidegrees({req_ch.raw_high_byte, req_ch.raw_low_byte}));
      end
      if (rsp_fire) begin
         got = '{rsp_ch.is_negative, rsp_ch.bcd_value, rsp_ch.overflow};
         if (expected_readings.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result sign=%b bcd=%h ovf=%b", $time,
                     got.is_negative, got.bcd_value, got.overflow);
         end else begin
            want = expected_readings.pop_front();
            if (got.is_negative !== want.is_negative) begin
               error_count++;
               $display("%0t: is_negative expected %b actual %b", $time,
                        want.is_negative, got.is_negative);
            end
            if (got.bcd_value !== want.bcd_value) begin
               error_count++;
               $display("%0t: bcd_value expected %h actual %h", $time,
                        want.bcd_value, got.bcd_value);
            end
            if (got.overflow !== want.overflow) begin
               error_count++;
               $display("%0t: overflow expected %b actual %b", $time,
                        want.overflow, got.overflow);
            end
         end
      end
      // Count stuck cycles only while work is outstanding
      if (req_fire || rsp_fire || (pending_raw.size() == 0 && !req_ch.valid &&
                                   expected_readings.size() == 0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Stimulus: directed readings, then random phases with different idle mixes
   initial begin
      logic [RAW_W-1:0] directed[$];
      int unsigned      idle_mix[4][2];
      req_ch.valid         = 1'b0;
      req_ch.raw_low_byte  = '0;
      req_ch.raw_high_byte = '0;
      rsp_ch.ready         = 1'b0;
      idle_mix = '{'{0, 0}, '{77, 0}, '{0, 77}, '{31, 31}};
      // zero, small fractions, one degree, the saturation edge on both signs,
      // the largest and most negative readings, byte extremes and mixed digits
      directed = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0010,
                   16'h0190, 16'h063F, 16'h0640, 16'hF9C1, 16'hF9C0, 16'h7FFF,
                   16'h8000, 16'h8001, 16'hFFFF, 16'hFFFE, 16'h00FF, 16'hFF00,
                   16'h5555, 16'hAAAA, 16'h0555, 16'h0123};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_mix[p][0];
         recv_stall_pct = idle_mix[p][1];
         if (p == 0) begin
            foreach (directed[i]) pending_raw.push_back(directed[i]);
         end
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            pending_raw.push_back(random_reading());
         end
         // Hold the sender until every outstanding result has arrived
         do @(posedge clock);
         while (pending_raw.size() != 0 || req_ch.valid || expected_readings.size() != 0);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/tbcd_pkg.sv
src/tbcd_req_if.sv
src/tbcd_rsp_if.sv
src/tbcd_scale.sv
src/tbcd_dabble_cell.sv
src/temperature_to_bcd_centidegrees_unit.sv
test/tb_top.sv
